/* rtl/core/pcs_pkg.sv */
package pcs_pkg;

  localparam int LANES      = 3;
  localparam int PIX_W      = 8;
  localparam int SEG_STAGES = 3;   // select, multiply, numerator
  localparam int DIV_STAGES = 9;   // one quotient bit per stage
  localparam int PIPE_STAGES = SEG_STAGES + DIV_STAGES;
  localparam int PROD_W     = 2 * PIX_W;
  localparam int NUM_W      = PROD_W + 2;
  localparam int DEN_W      = PIX_W + 1;
  localparam int QUO_W      = DIV_STAGES;

  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_KNEE1_IN  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_KNEE1_OUT = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_KNEE2_IN  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_KNEE2_OUT = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_COLOR     = 3'd4;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

  typedef struct packed {
    logic [PIX_W-1:0] knee1_in;
    logic [PIX_W-1:0] knee1_out;
    logic [PIX_W-1:0] knee2_in;
    logic [PIX_W-1:0] knee2_out;
  } knee_cfg_t;

  // segment front end to divider: round-half-up as (2n + d) / (2d)
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             force_max;
  } div_req_t;

endpackage

/* rtl/core/pcs_seg.sv */
module pcs_seg (
  input  logic                                   clk,
  input  logic [pcs_pkg::SEG_STAGES-1:0]         en,
  input  pcs_pkg::knee_cfg_t                     knees,
  input  logic [pcs_pkg::PIX_W-1:0]              sample,
  output pcs_pkg::div_req_t                      req
);

  localparam int W = pcs_pkg::PIX_W;

  // stage 0: segment choice
  logic [W-1:0] base, den, slope, span;
  logic         neg, force_max;
  logic [W-1:0] base_r, den_r, slope_r, span_r;
  logic         neg_r, force_r;

  // stage 1: products
  logic [pcs_pkg::PROD_W-1:0] prod_bd, prod_st;
  logic [W-1:0]               den_m;
  logic                       neg_m, force_m;

  logic [pcs_pkg::PROD_W:0]   n_sum;
  logic [pcs_pkg::PROD_W-1:0] n_val;

  always_comb begin
    base      = '0;
    den       = knees.knee1_in;
    slope     = knees.knee1_out;
    span      = sample;
    neg       = 1'b0;
    force_max = 1'b0;
    priority if (sample < knees.knee1_in) begin
      base  = '0;
      den   = knees.knee1_in;
      slope = knees.knee1_out;
      span  = sample;
    end else if (sample < knees.knee2_in) begin
      base = knees.knee1_out;
      den  = knees.knee2_in - knees.knee1_in;
      span = sample - knees.knee1_in;
      if (knees.knee2_out >= knees.knee1_out) begin
        slope = knees.knee2_out - knees.knee1_out;
      end else begin
        slope = knees.knee1_out - knees.knee2_out;
        neg   = 1'b1;
      end
    end else begin
      base      = knees.knee2_out;
      den       = pcs_pkg::PIX_MAX - knees.knee2_in;
      slope     = pcs_pkg::PIX_MAX - knees.knee2_out;
      span      = sample - knees.knee2_in;
      force_max = (knees.knee2_in == pcs_pkg::PIX_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      base_r  <= base;
      den_r   <= den;
      slope_r <= slope;
      span_r  <= span;
      neg_r   <= neg;
      force_r <= force_max;
    end
    if (en[1]) begin
      prod_bd <= {{W{1'b0}}, base_r} * {{W{1'b0}}, den_r};
      prod_st <= {{W{1'b0}}, slope_r} * {{W{1'b0}}, span_r};
      den_m   <= den_r;
      neg_m   <= neg_r;
      force_m <= force_r;
    end
    if (en[2]) begin
      req.num       <= {1'b0, n_val, 1'b0} + {{(pcs_pkg::NUM_W-W){1'b0}}, den_m};
      req.den       <= {den_m, 1'b0};
      req.force_max <= force_m;
    end
  end

  // the line value is never negative and never exceeds 255 * den
  always_comb begin
    if (neg_m) begin
      n_sum = {1'b0, prod_bd} - {1'b0, prod_st};
    end else begin
      n_sum = {1'b0, prod_bd} + {1'b0, prod_st};
    end
    n_val = n_sum[pcs_pkg::PROD_W-1:0];
  end

endmodule

/* rtl/core/pcs_div.sv */
module pcs_div (
  input  logic                             clk,
  input  logic [pcs_pkg::DIV_STAGES-1:0]   en,
  input  pcs_pkg::div_req_t                req,
  output logic [pcs_pkg::PIX_W-1:0]        result
);

  localparam int N  = pcs_pkg::DIV_STAGES;
  localparam int NW = pcs_pkg::NUM_W;
  localparam int QW = pcs_pkg::QUO_W;

  logic [NW-1:0]               rem   [N+1];
  logic [QW-1:0]               quo   [N+1];
  logic [pcs_pkg::DEN_W-1:0]   den   [N+1];
  logic                        fmax  [N+1];

  assign rem[0]  = req.num;
  assign quo[0]  = '0;
  assign den[0]  = req.den;
  assign fmax[0] = req.force_max;

  // stage j resolves quotient bit N-1-j
  for (genvar j = 0; j < N; j++) begin : g_stage
    localparam int SH = N - 1 - j;
    logic [NW-1:0] trial;
    logic          fits;

    assign trial = {{(NW - pcs_pkg::DEN_W){1'b0}}, den[j]} << SH;
    assign fits  = (rem[j] >= trial);

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem[j+1]  <= fits ? rem[j] - trial : rem[j];
        quo[j+1]  <= quo[j] | (QW'(fits) << SH);
        den[j+1]  <= den[j];
        fmax[j+1] <= fmax[j];
      end
    end
  end

  always_comb begin
    if (fmax[N] || quo[N][QW-1:pcs_pkg::PIX_W] != '0) begin
      result = pcs_pkg::PIX_MAX;
    end else begin
      result = quo[N][pcs_pkg::PIX_W-1:0];
    end
  end

endmodule

/* rtl/core/piecewise_linear_contrast_stretch_top.sv */
// Channel  Dir  Signals                       Payload
// s        in   s_tvalid s_tready s_tdata     sample_0, sample_1, sample_2
// m        out  m_tvalid m_tready m_tdata     out_0, out_1, out_2
// cfg      in   cfg_we cfg_addr cfg_wdata     knee1_in knee1_out knee2_in knee2_out color_mode
//
// One pixel per clock sustained while m_tready is high; a pixel passes through
// 3 segment stages, 9 divider stages with one quotient bit each, and the output
// register; the first stage loads on the accepting edge.
// Three lanes run the same segment/divider pipe, one per channel.
// rst clears valid bits and m_tvalid and presets knees and color_mode; no clearing pass.
// A stage holds only when every stage after it is full, so bubbles collapse
// while m_tready is low.
module piecewise_linear_contrast_stretch_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [23:0]                       s_tdata,   // sample_0, sample_1, sample_2
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [23:0]                       m_tdata,   // out_0, out_1, out_2
  input  logic                              cfg_we,
  input  logic [pcs_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [pcs_pkg::PIX_W-1:0]         cfg_wdata
);

  localparam int S = pcs_pkg::PIPE_STAGES;
  localparam int W = pcs_pkg::PIX_W;
  localparam int L = pcs_pkg::LANES;

  pcs_pkg::knee_cfg_t knees;
  logic               color_mode;

  logic [S-1:0] valid;
  logic [S:0]   rdy;
  logic [W-1:0] lane_out [L];

  always_ff @(posedge clk) begin
    if (rst) begin
      knees.knee1_in  <= '0;
      knees.knee1_out <= '0;
      knees.knee2_in  <= pcs_pkg::PIX_MAX;
      knees.knee2_out <= pcs_pkg::PIX_MAX;
      color_mode      <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pcs_pkg::REG_KNEE1_IN:  knees.knee1_in  <= cfg_wdata;
        pcs_pkg::REG_KNEE1_OUT: knees.knee1_out <= cfg_wdata;
        pcs_pkg::REG_KNEE2_IN:  knees.knee2_in  <= cfg_wdata;
        pcs_pkg::REG_KNEE2_OUT: knees.knee2_out <= cfg_wdata;
        pcs_pkg::REG_COLOR:     color_mode      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rdy[S] = !m_tvalid || m_tready;
    for (int k = S - 1; k >= 0; k--) begin
      rdy[k] = !valid[k] || rdy[k+1];
    end
  end

  assign s_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (rdy[0]) begin
        valid[0] <= s_tvalid;
      end
      for (int k = 1; k < S; k++) begin
        if (rdy[k]) begin
          valid[k] <= valid[k-1];
        end
      end
      if (rdy[S]) begin
        m_tvalid <= valid[S-1];
      end
    end
  end

  for (genvar i = 0; i < L; i++) begin : g_lane
    pcs_pkg::div_req_t req;

    pcs_seg u_seg (
      .clk    (clk),
      .en     (rdy[pcs_pkg::SEG_STAGES-1:0]),
      .knees  (knees),
      .sample (s_tdata[i*W +: W]),
      .req    (req)
    );

    pcs_div u_div (
      .clk    (clk),
      .en     (rdy[S-1:pcs_pkg::SEG_STAGES]),
      .req    (req),
      .result (lane_out[i])
    );
  end

  // merge: gray mode keeps lane 0 only
  always_ff @(posedge clk) begin
    if (rdy[S]) begin
      m_tdata[W-1:0] <= lane_out[0];
      for (int i = 1; i < L; i++) begin
        m_tdata[i*W +: W] <= color_mode ? lane_out[i] : '0;
      end
    end
  end

  a_gray_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !color_mode && $stable(color_mode) && $past(m_tvalid && m_tready)
      |-> m_tdata[23:8] == '0)
    else $error("gray mode result with nonzero upper lanes");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> valid[0])
    else $error("accepted request not in first stage");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready && (&valid) |-> !s_tready)
    else $error("request taken with pipe full and output stalled");

  a_bubble_ready: assert property (@(posedge clk) disable iff (rst)
    !valid[0] |-> s_tready)
    else $error("first stage empty but input not ready");

endmodule
